// ----- hw/rtl/dsa_pkg.sv -----
// Shared constants and control types for the decimal scale alignment block.
`timescale 1ns / 1ps

package dsa_pkg;

    // Default mantissa width in bits.
    localparam int MANT_BITS_DEF = 96;

    // The scaler works on 32-bit limbs, one limb per cycle while run is requested.
    localparam int LIMB_BITS = 32;

    // A limb times ten plus a carry below ten fits in this many carry bits.
    localparam int CARRY_BITS = 4;

    // Port widths of the mantissa halves and the exponent.
    localparam int LOW_BITS   = 64;
    localparam int HIGH_BITS  = 32;
    localparam int FIELD_BITS = LOW_BITS + HIGH_BITS;
    localparam int EXP_BITS   = 8;

    // Requests from the sequencer to the limb-serial scaler.
    typedef struct packed {
        logic load;
        logic run;
    } t_scl_ctrl;

    // Status back from the scaler.
    typedef struct packed {
        logic step_end;
        logic fits;
    } t_scl_stat;

endpackage

// ----- hw/rtl/dsa_scaler.sv -----
// Limb-serial multiply-by-ten unit with overflow check for one mantissa.
`timescale 1ns / 1ps

module dsa_scaler #(
    parameter int MANT_BITS = dsa_pkg::MANT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dsa_pkg::t_scl_ctrl    i_ctrl,
    input  logic [((MANT_BITS + dsa_pkg::LIMB_BITS - 1) / dsa_pkg::LIMB_BITS)
                  * dsa_pkg::LIMB_BITS - 1:0] i_load_val,
    output logic [((MANT_BITS + dsa_pkg::LIMB_BITS - 1) / dsa_pkg::LIMB_BITS)
                  * dsa_pkg::LIMB_BITS - 1:0] o_mant,
    output dsa_pkg::t_scl_stat    o_stat
);

    localparam int LB   = dsa_pkg::LIMB_BITS;
    localparam int CB   = dsa_pkg::CARRY_BITS;
    localparam int NL   = (MANT_BITS + LB - 1) / LB;
    localparam int W    = NL * LB;
    localparam int LW   = (NL > 1) ? $clog2(NL) : 1;
    localparam int TOPB = MANT_BITS - (NL - 1) * LB;
    localparam logic [LB-1:0] TOP_MASK = {LB{1'b1}} >> (LB - TOPB);
    localparam logic [LW-1:0] LAST_LIMB = LW'(NL - 1);

    logic [W-1:0]    r_m;
    logic [W-1:0]    r_prod;
    logic [CB-1:0]   r_carry;
    logic [LW-1:0]   r_limb;

    logic [LB+CB-1:0] wide;
    logic [LB-1:0]    prod_limb;
    logic [CB-1:0]    c_next;
    logic             last;
    logic             fits;
    logic [W+LB-1:0]  prod_cat;
    logic [W+LB-1:0]  rot_cat;
    logic [W-1:0]     n_prod;
    logic [W-1:0]     n_rot;

    // The low limb times ten is the limb shifted by three plus the limb shifted by one.
    assign wide = ({{CB{1'b0}}, r_m[LB-1:0]} << 3) + ({{CB{1'b0}}, r_m[LB-1:0]} << 1)
                + {{LB{1'b0}}, r_carry};
    assign prod_limb = wide[LB-1:0];
    assign c_next    = wide[LB+CB-1:LB];
    assign last      = (r_limb == LAST_LIMB);

    // Only the top limb can hold bits at or above the mantissa width.
    assign fits = (c_next == '0) && ((prod_limb & ~TOP_MASK) == '0);

    assign prod_cat = {prod_limb, r_prod};
    assign n_prod   = prod_cat[W+LB-1:LB];
    assign rot_cat  = {r_m[LB-1:0], r_m};
    assign n_rot    = rot_cat[W+LB-1:LB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_limb  <= '0;
        end else if (i_ctrl.load) begin
            r_carry <= '0;
            r_limb  <= '0;
        end else if (i_ctrl.run) begin
            r_carry <= last ? '0 : c_next;
            r_limb  <= last ? '0 : r_limb + LW'(1);
        end
    end

    // After a full pass the rotation has brought the old value back; it is kept on overflow.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_m <= i_load_val;
        end else if (i_ctrl.run) begin
            r_m    <= (last && fits) ? n_prod : n_rot;
            r_prod <= n_prod;
        end
    end

    assign o_mant          = r_m;
    assign o_stat.step_end = i_ctrl.run && last;
    assign o_stat.fits     = fits;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.load && i_ctrl.run))
        else $error("scaler load and run requested together");

    a_limb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_limb <= LAST_LIMB)
        else $error("scaler limb counter out of range");

    a_pass_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.step_end |=> (r_limb == '0 && r_carry == '0))
        else $error("scaler pass did not restart from the low limb");

endmodule

// ----- hw/rtl/decimal_scale_alignment_top.sv -----
// Top level: aligns two decimal operands to the larger scale, one limb per cycle.
`timescale 1ns / 1ps
// The sequencer goes from idle to done, through the run state when it has S multiply-by-ten
// steps to do (the scale difference, or fewer when an overflow stops it).
// Each step runs one 32-bit limb per cycle through a single times-ten adder.
// Throughput: one request at a time; the next one is taken after the result is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops the result valid.

module decimal_scale_alignment_top #(
    parameter int MANT_BITS = dsa_pkg::MANT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_mant_a_low,
    input  logic [31:0] i_mant_a_high,
    input  logic [7:0]  i_exp_a,
    input  logic [63:0] i_mant_b_low,
    input  logic [31:0] i_mant_b_high,
    input  logic [7:0]  i_exp_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_out_a_low,
    output logic [31:0] o_out_a_high,
    output logic [63:0] o_out_b_low,
    output logic [31:0] o_out_b_high,
    output logic [7:0]  o_common_exp,
    output logic        o_overflow_error
);

    localparam int LB = dsa_pkg::LIMB_BITS;
    localparam int FB = dsa_pkg::FIELD_BITS;
    localparam int LO = dsa_pkg::LOW_BITS;
    localparam int EB = dsa_pkg::EXP_BITS;
    localparam int W  = ((MANT_BITS + LB - 1) / LB) * LB;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [EB-1:0]      r_cnt;
    logic               r_scale_a;
    logic               r_err;
    logic [EB-1:0]      r_exp;
    logic [W-1:0]       r_other;

    dsa_pkg::t_scl_ctrl scl_ctrl;
    dsa_pkg::t_scl_stat scl_stat;

    logic [FB-1:0]      in_a;
    logic [FB-1:0]      in_b;
    logic [W-1:0]       ld_a;
    logic [W-1:0]       ld_b;
    logic               a_smaller;
    logic [EB-1:0]      diff;
    logic [W-1:0]       scaled;
    logic [W-1:0]       res_a;
    logic [W-1:0]       res_b;
    logic [FB-1:0]      out_a;
    logic [FB-1:0]      out_b;
    logic               in_acc;

    assign in_a = {i_mant_a_high, i_mant_a_low};
    assign in_b = {i_mant_b_high, i_mant_b_low};

    // Bits at or above the mantissa width are dropped on entry.
    genvar gi;
    generate
        for (gi = 0; gi < W; gi++) begin : g_load
            if (gi < FB && gi < MANT_BITS) begin : g_in
                assign ld_a[gi] = in_a[gi];
                assign ld_b[gi] = in_b[gi];
            end else begin : g_zero
                assign ld_a[gi] = 1'b0;
                assign ld_b[gi] = 1'b0;
            end
        end
        for (gi = 0; gi < FB; gi++) begin : g_out
            if (gi < W) begin : g_in
                assign out_a[gi] = res_a[gi];
                assign out_b[gi] = res_b[gi];
            end else begin : g_zero
                assign out_a[gi] = 1'b0;
                assign out_b[gi] = 1'b0;
            end
        end
    endgenerate

    assign a_smaller = (i_exp_a < i_exp_b);
    assign diff      = a_smaller ? (i_exp_b - i_exp_a) : (i_exp_a - i_exp_b);
    assign in_acc    = i_valid && (r_state == S_IDLE);

    assign scl_ctrl.load = in_acc;
    assign scl_ctrl.run  = (r_state == S_RUN);

    dsa_scaler #(
        .MANT_BITS (MANT_BITS)
    ) u_scaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (scl_ctrl),
        .i_load_val (a_smaller ? ld_a : ld_b),
        .o_mant     (scaled),
        .o_stat     (scl_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_err   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt     <= diff;
                        r_err     <= 1'b0;
                        r_scale_a <= a_smaller;
                        r_exp     <= a_smaller ? i_exp_b : i_exp_a;
                        r_other   <= a_smaller ? ld_b : ld_a;
                        r_state   <= (diff == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (scl_stat.step_end) begin
                        if (!scl_stat.fits) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt - EB'(1);
                            if (r_cnt == EB'(1)) begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign res_a = r_scale_a ? scaled : r_other;
    assign res_b = r_scale_a ? r_other : scaled;

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_DONE);
    assign o_out_a_low      = out_a[LO-1:0];
    assign o_out_a_high     = out_a[FB-1:LO];
    assign o_out_b_low      = out_b[LO-1:0];
    assign o_out_b_high     = out_b[FB-1:LO];
    assign o_common_exp     = r_exp;
    assign o_overflow_error = r_err;

    a_run_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt != '0))
        else $error("scaling running with no steps left");

    a_err_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_err) |-> $past(scl_stat.step_end && !scl_stat.fits))
        else $error("overflow flag set without an overflowing step");

    a_equal_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_exp_a == i_exp_b) |=> (o_valid && !o_overflow_error))
        else $error("equal scales did not pass straight through");

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !r_err)
        else $error("scaling continued after an overflow");

endmodule

// ----- bench/decimal_scale_alignment_top_test.sv -----
// Self-checking testbench for the decimal scale alignment top level.
`timescale 1ns / 1ps

module decimal_scale_alignment_top_test;

    localparam int FIELD_BITS   = dsa_pkg::FIELD_BITS;
    localparam int EXP_BITS     = dsa_pkg::EXP_BITS;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_ITEMS = 1150;
    localparam logic [FIELD_BITS-1:0] MANT_MAX = '1;

    typedef struct packed {
        logic [FIELD_BITS-1:0] mant_a;
        logic [EXP_BITS-1:0]   exp_a;
        logic [FIELD_BITS-1:0] mant_b;
        logic [EXP_BITS-1:0]   exp_b;
    } t_operand_pair;

    typedef struct packed {
        logic [FIELD_BITS-1:0] mant_a;
        logic [FIELD_BITS-1:0] mant_b;
        logic [EXP_BITS-1:0]   scale;
        logic                  overflow;
    } t_aligned;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_mant_a_low;
    logic [31:0] i_mant_a_high;
    logic [7:0]  i_exp_a;
    logic [63:0] i_mant_b_low;
    logic [31:0] i_mant_b_high;
    logic [7:0]  i_exp_b;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_out_a_low;
    logic [31:0] o_out_a_high;
    logic [63:0] o_out_b_low;
    logic [31:0] o_out_b_high;
    logic [7:0]  o_common_exp;
    logic        o_overflow_error;

    t_aligned pending_alignments[$];
    int       mismatch_count = 0;
    int       stall_cycles = 0;
    bit       no_idle = 1'b0;

    decimal_scale_alignment_top #(
        .MANT_BITS(FIELD_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mant_a_low    (i_mant_a_low),
        .i_mant_a_high   (i_mant_a_high),
        .i_exp_a         (i_exp_a),
        .i_mant_b_low    (i_mant_b_low),
        .i_mant_b_high   (i_mant_b_high),
        .i_exp_b         (i_exp_b),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_a_low     (o_out_a_low),
        .o_out_a_high    (o_out_a_high),
        .o_out_b_low     (o_out_b_low),
        .o_out_b_high    (o_out_b_high),
        .o_common_exp    (o_common_exp),
        .o_overflow_error(o_overflow_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Scales the operand with the smaller exponent up by powers of ten, stopping
    // at the last value that still fits in the mantissa width.
    function automatic t_aligned predict_alignment(t_operand_pair p);
        t_aligned              r;
        logic [FIELD_BITS-1:0] m;
        logic [FIELD_BITS+3:0] prod;
        int                    steps;
        int                    i;
        bit                    scale_a;
        scale_a = (p.exp_a < p.exp_b);
        m = scale_a ? p.mant_a : p.mant_b;
        steps = scale_a ? int'(p.exp_b - p.exp_a) : int'(p.exp_a - p.exp_b);
        r.overflow = 1'b0;
        for (i = 0; i < steps && !r.overflow; i++) begin
            prod = {4'd0, m} * 4'd10;
            if (prod[FIELD_BITS+3:FIELD_BITS] != 4'd0) begin
                r.overflow = 1'b1;
            end else begin
                m = prod[FIELD_BITS-1:0];
            end
        end
        r.scale  = scale_a ? p.exp_b : p.exp_a;
        r.mant_a = scale_a ? m : p.mant_a;
        r.mant_b = scale_a ? p.mant_b : m;
        return r;
    endfunction

    function automatic t_operand_pair make_pair(logic [FIELD_BITS-1:0] ma, int ea,
                                                logic [FIELD_BITS-1:0] mb, int eb);
        t_operand_pair p;
        p.mant_a = ma;
        p.exp_a  = EXP_BITS'(ea);
        p.mant_b = mb;
        p.exp_b  = EXP_BITS'(eb);
        return p;
    endfunction

    // Mostly pairs whose exponent gap is within reach of a full-width mantissa,
    // plus mantissas just around the overflow edge, zero mantissas with long gaps,
    // equal scales and fully random requests.
    function automatic t_operand_pair random_pair();
        t_operand_pair         p;
        logic [FIELD_BITS-1:0] scaled;
        logic [FIELD_BITS-1:0] other;
        logic [FIELD_BITS-1:0] tens;
        int                    kind;
        int                    diff;
        int                    lo;
        int                    k;
        kind  = $urandom_range(0, 99);
        other = {$urandom, $urandom, $urandom} >> $urandom_range(0, FIELD_BITS);
        if (kind >= 75 && kind < 85) begin
            return make_pair({$urandom, $urandom, $urandom}, $urandom_range(0, 255),
                             {$urandom, $urandom, $urandom}, $urandom_range(0, 255));
        end
        if (kind < 60) begin
            scaled = {$urandom, $urandom, $urandom} >> $urandom_range(0, FIELD_BITS);
            diff   = $urandom_range(0, 30);
        end else if (kind < 75) begin
            k    = $urandom_range(1, 28);
            tens = 1;
            repeat (k) tens = tens * 10;
            scaled = MANT_MAX / tens + $urandom_range(0, 4) - 2;
            diff   = k + $urandom_range(0, 1);
        end else if (kind < 95) begin
            scaled = {$urandom, $urandom, $urandom};
            diff   = 0;
        end else begin
            scaled = '0;
            diff   = $urandom_range(0, 255);
        end
        lo = $urandom_range(0, 255 - diff);
        if ($urandom_range(0, 1) == 1) begin
            p = make_pair(scaled, lo, other, lo + diff);
        end else begin
            p = make_pair(other, lo + diff, scaled, lo);
        end
        return p;
    endfunction

    task automatic send_pair(input t_operand_pair p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mant_a_low  <= p.mant_a[63:0];
        i_mant_a_high <= p.mant_a[95:64];
        i_exp_a       <= p.exp_a;
        i_mant_b_low  <= p.mant_b[63:0];
        i_mant_b_high <= p.mant_b[95:64];
        i_exp_b       <= p.exp_b;
        do @(posedge i_clk); while (!o_ready);
        pending_alignments.push_back(predict_alignment(p));
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_alignments.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] got,
                               input logic [FIELD_BITS-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    task automatic test_equal_scales();
        send_pair(make_pair(MANT_MAX, 0, MANT_MAX, 0));
        send_pair(make_pair(MANT_MAX, 255, '0, 255));
        send_pair(make_pair({$urandom, $urandom, $urandom}, 128,
                            {$urandom, $urandom, $urandom}, 128));
    endtask

    // A zero mantissa never overflows, so these run the full exponent gap, of up to 255 steps.
    task automatic test_zero_mantissa();
        send_pair(make_pair('0, 0, MANT_MAX, 255));
        send_pair(make_pair(MANT_MAX, 255, '0, 0));
        send_pair(make_pair('0, 7, '0, 200));
    endtask

    // Ten to the 28th still fits in 96 bits, ten to the 29th does not.
    task automatic test_power_of_ten_limits();
        send_pair(make_pair(1, 0, 5, 28));
        send_pair(make_pair(1, 0, 5, 29));
        send_pair(make_pair(5, 255, 1, 0));
        send_pair(make_pair(MANT_MAX, 3, 1, 4));
        send_pair(make_pair(MANT_MAX, 4, 1, 3));
    endtask

    task automatic test_overflow_edge();
        logic [FIELD_BITS-1:0] tenth;
        tenth = MANT_MAX / 10;
        send_pair(make_pair(tenth, 0, MANT_MAX, 1));
        send_pair(make_pair(MANT_MAX, 1, tenth + 1, 0));
        send_pair(make_pair({32'hFFFF_FFFF, 64'h0}, 0, 1, 1));
        send_pair(make_pair({32'h1999_9999, 64'h0}, 0, 1, 1));
        send_pair(make_pair(1, 9, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0));
        send_pair(make_pair(1, 10, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0));
    endtask

    task automatic test_random_operands(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_pair(random_pair());
        end
        no_idle = 1'b0;
    endtask

    // The sender holds off until the block has returned every result.
    task automatic test_sender_pause();
        repeat (5) send_pair(random_pair());
        wait_for_results();
        repeat (5) send_pair(random_pair());
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_mant_a_low  <= '0;
        i_mant_a_high <= '0;
        i_exp_a       <= '0;
        i_mant_b_low  <= '0;
        i_mant_b_high <= '0;
        i_exp_b       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_equal_scales();
        test_zero_mantissa();
        test_power_of_ten_limits();
        test_overflow_edge();
        test_random_operands(RANDOM_ITEMS / 2);
        test_sender_pause();
        test_random_operands(RANDOM_ITEMS / 2);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[decimal_scale_alignment_top] OK");
        end else begin
            $display("[decimal_scale_alignment_top] ERROR");
        end
        $finish;
    end

    // Result side: ready may drop for a random stall before each result.
    initial begin
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_aligned want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_alignments.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_alignments.pop_front();
                check_field("out_a", {o_out_a_high, o_out_a_low}, want.mant_a);
                check_field("out_b", {o_out_b_high, o_out_b_low}, want.mant_b);
                check_field("common_exp", FIELD_BITS'(o_common_exp), FIELD_BITS'(want.scale));
                check_field("overflow_error", FIELD_BITS'(o_overflow_error),
                            FIELD_BITS'(want.overflow));
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[decimal_scale_alignment_top] ERROR");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_scaler.sv
hw/rtl/decimal_scale_alignment_top.sv
bench/decimal_scale_alignment_top_test.sv
